>>> rtl/core/dabt_pkg.sv
package dabt_pkg;

    // Command codes carried on the cmd field.
    localparam logic CMD_DAYS   = 1'b0;
    localparam logic CMD_MONTHS = 1'b1;

    // Field widths.
    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int TERM_W  = 16;
    localparam int STEP_W  = 6;

    // Month codes for January, February and December.
    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    // Divisibility by 25 of a 14-bit year: multiply by the inverse of 25
    // modulo 2^14 and compare against floor((2^14 - 1) / 25).
    localparam logic [YEAR_W-1:0] INV25       = 14'd7209;
    localparam logic [YEAR_W-1:0] DIV25_LIMIT = 14'd655;

    // Quotient by 12 of a 16-bit count: (n * 43691) >> 19 is exact here.
    localparam logic [TERM_W-1:0] RECIP12       = 16'd43691;
    localparam int                RECIP12_SHIFT = 19;
    localparam int                QUOT_W        = 13;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEAP,
        ST_MUL,
        ST_YEARS,
        ST_STEP,
        ST_FIX,
        ST_DONE
    } state_t;

    // Results of the calendar unit for the current date.
    typedef struct packed {
        logic [DAY_W-1:0]   month_len;
        logic               leap_calc;
        logic [MONTH_W-1:0] next_month;
        logic               year_wrap;
        logic [STEP_W-1:0]  step_len;
        logic               fits;
        logic [TERM_W-1:0]  rem_diff;
    } cal_res_t;

    // Number of days in a month, given the leap flag of its year.
    function automatic logic [DAY_W-1:0] days_in_month(
        input logic [MONTH_W-1:0] month,
        input logic               leap
    );
        logic [DAY_W-1:0] len;
        begin
            case (month)
                4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
                4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
                MONTH_FEB: len = leap ? 5'd29 : 5'd28;
                default:   len = 5'd0;
            endcase
            return len;
        end
    endfunction

endpackage

>>> rtl/core/date_advance_by_term.sv
// Channel | Direction | Handshake          | Payload
// input   | in        | in_valid/in_ready  | cmd, start_year, start_month, start_day, term
// output  | out       | out_valid/out_ready| end_year, end_month, end_day, end_is_leap
//
// One request is worked on at a time; in_ready is high only while idle.
// Days mode steps across one month boundary at a time and re-evaluates
// the leap flag for each year crossed. Months mode first jumps whole
// years with a multiply, then steps the remaining months one at a time.
// Each step uses the single calendar unit once.
// Reset clears the sequencer only; the result holds until out_ready.
module date_advance_by_term
    import dabt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               cmd,
    input  logic [YEAR_W-1:0]  start_year,
    input  logic [MONTH_W-1:0] start_month,
    input  logic [DAY_W-1:0]   start_day,
    input  logic [TERM_W-1:0]  term,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [YEAR_W-1:0]  end_year,
    output logic [MONTH_W-1:0] end_month,
    output logic [DAY_W-1:0]   end_day,
    output logic               end_is_leap
);

    state_t             state_reg, state_next;
    logic               cmd_reg, cmd_next;
    logic [YEAR_W-1:0]  year_reg, year_next;
    logic [MONTH_W-1:0] month_reg, month_next;
    logic [DAY_W-1:0]   day_reg, day_next;
    logic [DAY_W-1:0]   orig_reg, orig_next;
    logic [TERM_W-1:0]  rem_reg, rem_next;
    logic               leap_reg, leap_next;
    logic               jumped_reg, jumped_next;
    logic               nonzero_reg, nonzero_next;
    logic [QUOT_W-1:0]  quot_reg, quot_next;

    logic [2*TERM_W-1:0] recip_prod;
    logic [TERM_W-1:0]   quot_x12;
    cal_res_t            cal;

    dabt_cal u_cal (
        .cmd   (cmd_reg),
        .year  (year_reg),
        .month (month_reg),
        .day   (day_reg),
        .rem   (rem_reg),
        .leap  (leap_reg),
        .res   (cal)
    );

    // Whole years in the month count, and twelve times that.
    assign recip_prod = (2*TERM_W)'(rem_reg) * (2*TERM_W)'(RECIP12);
    assign quot_x12   = (TERM_W'(quot_reg) << 3) + (TERM_W'(quot_reg) << 2);

    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = (state_reg == ST_DONE);
    assign end_year    = year_reg;
    assign end_month   = month_reg;
    assign end_day     = day_reg;
    assign end_is_leap = leap_reg;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        year_reg    <= year_next;
        month_reg   <= month_next;
        day_reg     <= day_next;
        orig_reg    <= orig_next;
        rem_reg     <= rem_next;
        leap_reg    <= leap_next;
        jumped_reg  <= jumped_next;
        nonzero_reg <= nonzero_next;
        quot_reg    <= quot_next;
    end

    // Sequencer: next state and next values of the working registers.
    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        year_next    = year_reg;
        month_next   = month_reg;
        day_next     = day_reg;
        orig_next    = orig_reg;
        rem_next     = rem_reg;
        leap_next    = leap_reg;
        jumped_next  = jumped_reg;
        nonzero_next = nonzero_reg;
        quot_next    = quot_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next     = cmd;
                    year_next    = start_year;
                    day_next     = start_day;
                    orig_next    = start_day;
                    rem_next     = term;
                    jumped_next  = 1'b0;
                    nonzero_next = (term != '0);
                    if (start_month == 4'd0)
                    begin
                        month_next = MONTH_JAN;
                    end
                    else if (start_month > MONTH_DEC)
                    begin
                        month_next = MONTH_DEC;
                    end
                    else
                    begin
                        month_next = start_month;
                    end
                    state_next = ST_LEAP;
                end
            end

            ST_LEAP:
            begin
                leap_next = cal.leap_calc;
                if (cmd_reg == CMD_MONTHS && !jumped_reg)
                begin
                    state_next = ST_MUL;
                end
                else
                begin
                    state_next = ST_STEP;
                end
            end

            ST_MUL:
            begin
                quot_next  = recip_prod[RECIP12_SHIFT +: QUOT_W];
                state_next = ST_YEARS;
            end

            ST_YEARS:
            begin
                year_next   = year_reg + YEAR_W'(quot_reg);
                rem_next    = rem_reg - quot_x12;
                jumped_next = 1'b1;
                state_next  = ST_LEAP;
            end

            ST_STEP:
            begin
                if (rem_reg == '0)
                begin
                    state_next = (cmd_reg == CMD_MONTHS) ? ST_FIX : ST_DONE;
                end
                else if (cal.fits)
                begin
                    // Move to the next month, landing on the first in days mode.
                    rem_next   = cal.rem_diff;
                    month_next = cal.next_month;
                    if (cmd_reg == CMD_DAYS)
                    begin
                        day_next = DAY_W'(1);
                    end
                    if (cal.year_wrap)
                    begin
                        year_next  = year_reg + YEAR_W'(1);
                        state_next = ST_LEAP;
                    end
                end
                else
                begin
                    // The remaining days stay within this month.
                    day_next   = day_reg + rem_reg[DAY_W-1:0];
                    rem_next   = '0;
                    state_next = ST_DONE;
                end
            end

            ST_FIX:
            begin
                if (nonzero_reg)
                begin
                    day_next = (orig_reg > cal.month_len) ? cal.month_len : orig_reg;
                end
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // A transfer in always starts with the leap evaluation.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_LEAP))
        else $error("accepted request did not enter leap evaluation");

    // The month stays a real month in the step, fix and done states.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STEP || state_reg == ST_FIX || state_reg == ST_DONE)
        |-> (month_reg >= MONTH_JAN && month_reg <= MONTH_DEC))
        else $error("month register out of range");

    // After the year jump fewer than twelve months remain.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STEP && cmd_reg == CMD_MONTHS) |-> (rem_reg < TERM_W'(12)))
        else $error("months left over after year jump");

    // The leap flag shown with a result belongs to the result's year.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (leap_reg == cal.leap_calc))
        else $error("leap flag does not match end year");
`endif

endmodule

>>> rtl/core/dabt_cal.sv
module dabt_cal
    import dabt_pkg::*;
(
    input  logic               cmd,
    input  logic [YEAR_W-1:0]  year,
    input  logic [MONTH_W-1:0] month,
    input  logic [DAY_W-1:0]   day,
    input  logic [TERM_W-1:0]  rem,
    input  logic               leap,
    output cal_res_t           res
);

    logic [2*YEAR_W-1:0] inv_prod;
    logic [YEAR_W-1:0]   inv_low;
    logic                div25;
    logic [DAY_W-1:0]    len;
    logic [STEP_W-1:0]   step;

    // Gregorian leap rule: divisible by 4 and not by 100, or by 400.
    // With 4 given, 100 reduces to 25 and 400 reduces to 16.
    assign inv_prod = (2*YEAR_W)'(year) * (2*YEAR_W)'(INV25);
    assign inv_low  = inv_prod[YEAR_W-1:0];
    assign div25    = (inv_low <= DIV25_LIMIT);

    assign len = days_in_month(month, leap);

    // Days consumed to reach the first of the next month; one in months mode.
    always_comb
    begin
        if (cmd == CMD_MONTHS || day >= len)
        begin
            step = STEP_W'(1);
        end
        else
        begin
            step = STEP_W'(len) - STEP_W'(day) + STEP_W'(1);
        end
    end

    // The leap flag, month length, shared subtractor and month advance.
    always_comb
    begin
        res.month_len  = len;
        res.leap_calc  = (year[1:0] == 2'd0) && (!div25 || (year[3:0] == 4'd0));
        res.year_wrap  = (month == MONTH_DEC);
        res.next_month = (month == MONTH_DEC) ? MONTH_JAN : month + 4'd1;
        res.step_len   = step;
        res.fits       = (rem >= TERM_W'(step));
        res.rem_diff   = rem - TERM_W'(step);
    end

endmodule
